// ===== hdl/ctoi_pkg.sv =====
package ctoi_pkg;

    localparam int WORD_BITS = 32;
    localparam int TOL_W     = 17;
    localparam logic [TOL_W-1:0] TOL_RESET = 17'd66;

    // Bits of the second operand consumed per multiplier stage.
    localparam int MUL_DIG = 8;

    localparam int DIF_W = WORD_BITS + 1;
    localparam int CO_W  = 2 * WORD_BITS + 3;
    localparam int A_W   = 2 * WORD_BITS + 2;
    localparam int H_W   = 2 * WORD_BITS + 2;
    localparam int D_W   = 2 * CO_W;
    localparam int S_W   = 2 * WORD_BITS + 2;
    localparam int QB_W  = (WORD_BITS > TOL_W) ? WORD_BITS : TOL_W;

    function automatic int mul_lat(input int iw);
        return (iw + MUL_DIG - 1) / MUL_DIG + 2;
    endfunction

    typedef struct packed {
        logic signed [WORD_BITS-1:0] first_pos_x;
        logic signed [WORD_BITS-1:0] first_pos_y;
        logic signed [WORD_BITS-1:0] first_vel_x;
        logic signed [WORD_BITS-1:0] first_vel_y;
        logic        [WORD_BITS-2:0] first_radius;
        logic signed [WORD_BITS-1:0] second_pos_x;
        logic signed [WORD_BITS-1:0] second_pos_y;
        logic signed [WORD_BITS-1:0] second_vel_x;
        logic signed [WORD_BITS-1:0] second_vel_y;
        logic        [WORD_BITS-2:0] second_radius;
    } t_in_req;

    typedef struct packed {
        logic                 hit;
        logic [WORD_BITS-1:0] impact_time;
    } t_out_req;

    typedef struct packed {
        logic                   valid;
        logic signed [CO_W-1:0] a;
        logic signed [CO_W-1:0] h;
        logic signed [CO_W-1:0] c;
    } t_coef;

    typedef struct packed {
        logic                  valid;
        logic                  a_zero;
        logic                  disc_neg;
        logic [A_W-1:0]        a;
        logic signed [H_W-1:0] h;
        logic signed [D_W-1:0] disc;
    } t_disc;

    typedef struct packed {
        logic                  valid;
        logic                  skip;
        logic [A_W-1:0]        a;
        logic signed [H_W-1:0] h;
        logic [S_W-1:0]        s;
    } t_root;

    typedef struct packed {
        logic     valid;
        t_out_req data;
    } t_res;

endpackage

// ===== hdl/ctoi_mul.sv =====
module ctoi_mul
    import ctoi_pkg::*;
#(
    parameter int IW = 33
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic signed [IW-1:0]   i_a,
    input  logic signed [IW-1:0]   i_b,
    output logic signed [2*IW-1:0] o_p
);

    localparam int ND = (IW + MUL_DIG - 1) / MUL_DIG;
    localparam int BW = ND * MUL_DIG;
    localparam int PW = 2 * IW;

    logic [IW-1:0] n_ma;
    logic [IW-1:0] n_mb;

    logic [IW-1:0] r_ma  [ND];
    logic [BW-1:0] r_mb  [ND];
    logic          r_sg  [ND+1];
    logic [PW-1:0] r_acc [ND+1];
    logic [PW-1:0] r_p;

    always_comb begin
        n_ma = i_a[IW-1] ? IW'(-i_a) : IW'(i_a);
        n_mb = i_b[IW-1] ? IW'(-i_b) : IW'(i_b);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ma[0]  <= n_ma;
            r_mb[0]  <= BW'(n_mb);
            r_sg[0]  <= i_a[IW-1] ^ i_b[IW-1];
            r_acc[0] <= '0;
        end
    end

    // One digit of the second operand per stage, added at its weight.
    for (genvar j = 0; j < ND; j++) begin : g_dig
        logic [IW+MUL_DIG-1:0] w_pp;
        assign w_pp = {{MUL_DIG{1'b0}}, r_ma[j]}
                    * {{IW{1'b0}}, r_mb[j][j*MUL_DIG +: MUL_DIG]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_acc[j+1] <= r_acc[j] + (PW'(w_pp) << (j * MUL_DIG));
                r_sg[j+1]  <= r_sg[j];
            end
        end
        if (j < ND - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_ma[j+1] <= r_ma[j];
                    r_mb[j+1] <= r_mb[j];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= r_sg[ND] ? (~r_acc[ND] + 1'b1) : r_acc[ND];
        end
    end

    assign o_p = r_p;

endmodule

// ===== hdl/ctoi_coef.sv =====
module ctoi_coef
    import ctoi_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  logic    i_valid,
    input  t_in_req i_req,
    output t_coef   o_coef
);

    localparam int L1 = mul_lat(DIF_W);
    localparam int PW = 2 * DIF_W;

    logic                    r_v0;
    logic signed [DIF_W-1:0] r_dpx, r_dpy, r_dvx, r_dvy, r_rs;
    logic [L1-1:0]           r_vsh;
    logic                    r_coef_v;
    logic signed [CO_W-1:0]  r_a, r_h, r_c;

    logic signed [PW-1:0] w_vxx, w_vyy, w_pvx, w_pvy, w_pxx, w_pyy, w_rr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0     <= 1'b0;
            r_vsh    <= '0;
            r_coef_v <= 1'b0;
        end else if (i_en) begin
            r_v0     <= i_valid;
            r_vsh    <= {r_vsh[L1-2:0], r_v0};
            r_coef_v <= r_vsh[L1-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dpx <= DIF_W'(i_req.second_pos_x) - DIF_W'(i_req.first_pos_x);
            r_dpy <= DIF_W'(i_req.second_pos_y) - DIF_W'(i_req.first_pos_y);
            r_dvx <= DIF_W'(i_req.second_vel_x) - DIF_W'(i_req.first_vel_x);
            r_dvy <= DIF_W'(i_req.second_vel_y) - DIF_W'(i_req.first_vel_y);
            r_rs  <= DIF_W'(i_req.first_radius) + DIF_W'(i_req.second_radius);
            r_a   <= CO_W'(w_vxx) + CO_W'(w_vyy);
            r_h   <= CO_W'(w_pvx) + CO_W'(w_pvy);
            r_c   <= CO_W'(w_pxx) + CO_W'(w_pyy) - CO_W'(w_rr);
        end
    end

    ctoi_mul #(.IW(DIF_W)) u_vxx (.i_clk, .i_en, .i_a(r_dvx), .i_b(r_dvx), .o_p(w_vxx));
    ctoi_mul #(.IW(DIF_W)) u_vyy (.i_clk, .i_en, .i_a(r_dvy), .i_b(r_dvy), .o_p(w_vyy));
    ctoi_mul #(.IW(DIF_W)) u_pvx (.i_clk, .i_en, .i_a(r_dpx), .i_b(r_dvx), .o_p(w_pvx));
    ctoi_mul #(.IW(DIF_W)) u_pvy (.i_clk, .i_en, .i_a(r_dpy), .i_b(r_dvy), .o_p(w_pvy));
    ctoi_mul #(.IW(DIF_W)) u_pxx (.i_clk, .i_en, .i_a(r_dpx), .i_b(r_dpx), .o_p(w_pxx));
    ctoi_mul #(.IW(DIF_W)) u_pyy (.i_clk, .i_en, .i_a(r_dpy), .i_b(r_dpy), .o_p(w_pyy));
    ctoi_mul #(.IW(DIF_W)) u_rr  (.i_clk, .i_en, .i_a(r_rs),  .i_b(r_rs),  .o_p(w_rr));

    assign o_coef = {r_coef_v, r_a, r_h, r_c};

endmodule

// ===== hdl/ctoi_disc.sv =====
module ctoi_disc
    import ctoi_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  t_coef i_coef,
    output t_disc o_disc
);

    localparam int L2 = mul_lat(CO_W);

    logic [L2-1:0]         r_vd;
    logic [A_W-1:0]        r_ad [L2];
    logic signed [H_W-1:0] r_hd [L2];
    logic                  r_disc_v;
    logic                  r_a_zero;
    logic                  r_disc_neg;
    logic [A_W-1:0]        r_a;
    logic signed [H_W-1:0] r_h;
    logic signed [D_W-1:0] r_dval;

    logic signed [D_W-1:0] w_hh, w_ac;
    logic signed [D_W-1:0] n_disc;

    assign n_disc = w_hh - w_ac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd     <= '0;
            r_disc_v <= 1'b0;
        end else if (i_en) begin
            r_vd     <= {r_vd[L2-2:0], i_coef.valid};
            r_disc_v <= r_vd[L2-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ad[0] <= i_coef.a[A_W-1:0];
            r_hd[0] <= i_coef.h[H_W-1:0];
            for (int k = 1; k < L2; k++) begin
                r_ad[k] <= r_ad[k-1];
                r_hd[k] <= r_hd[k-1];
            end
            r_a        <= r_ad[L2-1];
            r_h        <= r_hd[L2-1];
            r_a_zero   <= (r_ad[L2-1] == '0);
            r_dval     <= n_disc;
            r_disc_neg <= n_disc[D_W-1];
        end
    end

    ctoi_mul #(.IW(CO_W)) u_hh (.i_clk, .i_en, .i_a(i_coef.h), .i_b(i_coef.h), .o_p(w_hh));
    ctoi_mul #(.IW(CO_W)) u_ac (.i_clk, .i_en, .i_a(i_coef.a), .i_b(i_coef.c), .o_p(w_ac));

    assign o_disc = {r_disc_v, r_a_zero, r_disc_neg, r_a, r_h, r_dval};

endmodule

// ===== hdl/ctoi_sqrt.sv =====
module ctoi_sqrt
    import ctoi_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  t_disc i_disc,
    output t_root o_root
);

    logic [D_W-1:0]        w_rem  [S_W];
    logic [S_W-1:0]        w_s    [S_W+1];
    logic                  w_v    [S_W+1];
    logic                  w_skip [S_W+1];
    logic [A_W-1:0]        w_a    [S_W+1];
    logic signed [H_W-1:0] w_h    [S_W+1];

    assign w_rem[0]  = i_disc.disc;
    assign w_s[0]    = '0;
    assign w_v[0]    = i_disc.valid;
    assign w_skip[0] = i_disc.a_zero | i_disc.disc_neg;
    assign w_a[0]    = i_disc.a;
    assign w_h[0]    = i_disc.h;

    // Stage i decides root bit k: setting it costs 2^(k+1)*s + 2^(2k) of the remainder.
    for (genvar i = 0; i < S_W; i++) begin : g_st
        localparam int K = S_W - 1 - i;
        logic [D_W-1:0]        w_term;
        logic                  w_fit;
        logic [S_W-1:0]        r_s;
        logic                  r_v;
        logic                  r_skip;
        logic [A_W-1:0]        r_a;
        logic signed [H_W-1:0] r_h;

        assign w_term = (D_W'(w_s[i]) << (K + 1)) + (D_W'(1'b1) << (2 * K));
        assign w_fit  = (w_rem[i] >= w_term);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= w_v[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_s    <= w_fit ? (w_s[i] | (S_W'(1'b1) << K)) : w_s[i];
                r_skip <= w_skip[i];
                r_a    <= w_a[i];
                r_h    <= w_h[i];
            end
        end

        if (i < S_W - 1) begin : g_rem
            logic [D_W-1:0] r_rem;
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem <= w_fit ? (w_rem[i] - w_term) : w_rem[i];
                end
            end
            assign w_rem[i+1] = r_rem;
        end

        assign w_s[i+1]    = r_s;
        assign w_v[i+1]    = r_v;
        assign w_skip[i+1] = r_skip;
        assign w_a[i+1]    = r_a;
        assign w_h[i+1]    = r_h;
    end

    assign o_root.valid = w_v[S_W];
    assign o_root.skip  = w_skip[S_W];
    assign o_root.a     = w_a[S_W];
    assign o_root.h     = w_h[S_W];
    assign o_root.s     = w_s[S_W];

endmodule

// ===== hdl/ctoi_div.sv =====
module ctoi_div
    import ctoi_pkg::*;
#(
    parameter int FRAC = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [TOL_W-1:0] i_tol,
    input  t_root            i_root,
    output t_res             o_res
);

    localparam int NSW = H_W + 2;
    localparam int NW  = NSW - 1 + FRAC;
    localparam int XW  = ((NW > A_W + QB_W) ? NW : A_W + QB_W) + 1;

    localparam logic [QB_W:0] MAXQ = {{(QB_W + 1 - WORD_BITS){1'b0}}, {WORD_BITS{1'b1}}};

    // Numerators of both roots.
    logic                  r0_v;
    logic                  r0_skip;
    logic [A_W-1:0]        r0_a;
    logic signed [NSW-1:0] r0_num [2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else if (i_en) begin
            r0_v <= i_root.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_skip   <= i_root.skip;
            r0_a      <= i_root.a;
            r0_num[0] <= -NSW'(i_root.h) - NSW'(i_root.s);
            r0_num[1] <= -NSW'(i_root.h) + NSW'(i_root.s);
        end
    end

    logic [XW-1:0]   w_rem  [2][QB_W];
    logic [QB_W-1:0] w_q    [2][QB_W+1];
    logic            w_neg  [2][QB_W+1];
    logic            w_ovf  [2][QB_W+1];
    logic            w_v    [QB_W+1];
    logic            w_skip [QB_W+1];
    logic [A_W-1:0]  w_a    [QB_W];

    // Overflow stage: a quotient of 2^QB_W or more is flagged and not resolved further.
    logic            r1_v;
    logic            r1_skip;
    logic [A_W-1:0]  r1_a;
    logic [XW-1:0]   r1_rem [2];
    logic            r1_neg [2];
    logic            r1_ovf [2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= r0_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_skip <= r0_skip;
            r1_a    <= r0_a;
            for (int l = 0; l < 2; l++) begin
                r1_rem[l] <= XW'(r0_num[l][NSW-2:0]) << FRAC;
                r1_neg[l] <= r0_num[l][NSW-1];
                r1_ovf[l] <= ((XW'(r0_num[l][NSW-2:0]) << FRAC) >= (XW'(r0_a) << QB_W));
            end
        end
    end

    assign w_v[0]    = r1_v;
    assign w_skip[0] = r1_skip;
    assign w_a[0]    = r1_a;

    for (genvar l = 0; l < 2; l++) begin : g_lane
        assign w_rem[l][0] = r1_rem[l];
        assign w_q[l][0]   = '0;
        assign w_neg[l][0] = r1_neg[l];
        assign w_ovf[l][0] = r1_ovf[l];

        for (genvar i = 0; i < QB_W; i++) begin : g_st
            localparam int K = QB_W - 1 - i;
            logic [XW-1:0]   w_dsh;
            logic            w_fit;
            logic [QB_W-1:0] r_q;
            logic            r_neg;
            logic            r_ovf;

            assign w_dsh = XW'(w_a[i]) << K;
            assign w_fit = (w_rem[l][i] >= w_dsh);

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_q   <= w_fit ? (w_q[l][i] | (QB_W'(1'b1) << K)) : w_q[l][i];
                    r_neg <= w_neg[l][i];
                    r_ovf <= w_ovf[l][i];
                end
            end

            if (i < QB_W - 1) begin : g_rem
                logic [XW-1:0] r_rem;
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_rem <= w_fit ? (w_rem[l][i] - w_dsh) : w_rem[l][i];
                    end
                end
                assign w_rem[l][i+1] = r_rem;
            end

            assign w_q[l][i+1]   = r_q;
            assign w_neg[l][i+1] = r_neg;
            assign w_ovf[l][i+1] = r_ovf;
        end
    end

    for (genvar i = 0; i < QB_W; i++) begin : g_ctl
        logic r_v;
        logic r_skip;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= w_v[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_skip <= w_skip[i];
            end
        end

        if (i < QB_W - 1) begin : g_a
            logic [A_W-1:0] r_a;
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_a <= w_a[i];
                end
            end
            assign w_a[i+1] = r_a;
        end

        assign w_v[i+1]    = r_v;
        assign w_skip[i+1] = r_skip;
    end

    // The earlier root wins when it is not in the past and not below the tolerance.
    logic [QB_W:0]        w_tolx;
    logic                 w_ok [2];
    logic                 n_hit;
    logic [QB_W-1:0]      n_q;
    logic                 n_ovf;
    logic [WORD_BITS-1:0] n_time;
    logic                 r_res_v;
    t_out_req             r_res_d;

    assign w_tolx = {{(QB_W + 1 - TOL_W){1'b0}}, i_tol};

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            w_ok[l] = !w_neg[l][QB_W]
                   && (w_ovf[l][QB_W] || ({1'b0, w_q[l][QB_W]} >= w_tolx));
        end
        n_hit = !w_skip[QB_W] && (w_ok[0] || w_ok[1]);
        n_q   = w_ok[0] ? w_q[0][QB_W] : w_q[1][QB_W];
        n_ovf = w_ok[0] ? w_ovf[0][QB_W] : w_ovf[1][QB_W];
        if (!n_hit) begin
            n_time = '0;
        end else if (n_ovf || ({1'b0, n_q} > MAXQ)) begin
            n_time = '1;
        end else begin
            n_time = n_q[WORD_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_v <= 1'b0;
        end else if (i_en) begin
            r_res_v <= w_v[QB_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res_d.hit         <= n_hit;
            r_res_d.impact_time <= n_time;
        end
    end

    assign o_res = {r_res_v, r_res_d};

endmodule

// ===== hdl/circle_time_of_impact.sv =====
// Throughput: one request per cycle while the input is not stalled (o_in_stall low),
// set by the fully pipelined multipliers, the one-bit-per-stage square root and the
// two one-bit-per-stage divider lanes.
// Reset (synchronous, active low) empties the pipeline and sets the tolerance to 66.
module circle_time_of_impact
    import ctoi_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  t_in_req          i_in_data,
    output logic             o_in_stall,
    output logic             o_out_valid,
    output t_out_req         o_out_data,
    input  logic             i_out_stall,
    input  logic             i_tol_we,
    input  logic [TOL_W-1:0] i_tol_data
);

    logic [TOL_W-1:0] r_tol;
    logic             r_ov;
    t_out_req         r_od;
    logic             r_skid_v;
    t_out_req         r_sd;

    logic  w_en;
    logic  w_take;
    t_coef w_coef;
    t_disc w_disc;
    t_root w_root;
    t_res  w_res;

    // The pipeline freezes only while the skid register holds a result.
    assign w_en   = !r_skid_v;
    assign w_take = !r_ov || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
        end else if (i_tol_we) begin
            r_tol <= i_tol_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov     <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (w_take) begin
                r_ov     <= 1'b1;
                r_skid_v <= 1'b0;
            end
        end else if (w_take) begin
            r_ov <= w_res.valid;
        end else if (w_res.valid) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (w_take) begin
                r_od <= r_sd;
            end
        end else if (w_take) begin
            r_od <= w_res.data;
        end else begin
            r_sd <= w_res.data;
        end
    end

    ctoi_coef u_coef (
        .i_clk,
        .i_rst_n,
        .i_en    (w_en),
        .i_valid (i_in_valid),
        .i_req   (i_in_data),
        .o_coef  (w_coef)
    );

    ctoi_disc u_disc (
        .i_clk,
        .i_rst_n,
        .i_en    (w_en),
        .i_coef  (w_coef),
        .o_disc  (w_disc)
    );

    ctoi_sqrt u_sqrt (
        .i_clk,
        .i_rst_n,
        .i_en    (w_en),
        .i_disc  (w_disc),
        .o_root  (w_root)
    );

    ctoi_div #(.FRAC(FRAC_BITS)) u_div (
        .i_clk,
        .i_rst_n,
        .i_en    (w_en),
        .i_tol   (r_tol),
        .i_root  (w_root),
        .o_res   (w_res)
    );

    assign o_in_stall  = r_skid_v;
    assign o_out_valid = r_ov;
    assign o_out_data  = r_od;

endmodule
